### design/mtlooper_pkg.sv
// mtlooper_pkg: shared types and constants of the multitrack overdub looper
// action codes, the command beat passed from front to back, back-end states
// no dependencies
`timescale 1ns / 1ps

package mtlooper_pkg;

  localparam int SAMPLE_W = 16;
  localparam int MASK_W   = 4;
  localparam int SEEK_W   = 19;
  localparam int CFG_W    = 3;
  localparam int ACTION_W = 2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_SAMPLE = 2'd0,
    ACT_MARK   = 2'd1,
    ACT_SEEK   = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_t;

  // classified command: masks already limited to taking-part tracks,
  // seek already clamped into the store
  typedef struct packed {
    action_t                     action;
    logic signed [SAMPLE_W-1:0]  sample;
    logic        [MASK_W-1:0]    rec_mask;
    logic        [MASK_W-1:0]    play_mask;
    logic        [SEEK_W-1:0]    seek;
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RREC,
    S_WREC,
    S_RPLAY,
    S_ACC,
    S_OUT,
    S_CLEAR
  } bk_state_t;

endpackage

### design/mtlooper_ram.sv
// mtlooper_ram: generic simple dual-port ram, one write and one read port
// registered read, read-old on a same-address collision; no dependencies
`timescale 1ns / 1ps

module mtlooper_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/mtlooper_front.sv
// mtlooper_front: accepts input beats, holds the active_tracks register
// and classifies each action into a cmd_t for the queue; uses mtlooper_pkg
`timescale 1ns / 1ps

module mtlooper_front #(
  parameter int TRACKS     = 4,
  parameter int LOOP_DEPTH = 524288
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [mtlooper_pkg::CFG_W-1:0]         cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [mtlooper_pkg::ACTION_W-1:0]      action,
  input  logic signed [mtlooper_pkg::SAMPLE_W-1:0] sample_in,
  input  logic [mtlooper_pkg::MASK_W-1:0]        record_mask,
  input  logic [mtlooper_pkg::MASK_W-1:0]        play_mask,
  input  logic [mtlooper_pkg::SEEK_W-1:0]        seek_position,
  input  logic                                   hold,
  output logic                                   push_valid,
  input  logic                                   push_ready,
  output mtlooper_pkg::cmd_t                     push_data
);
  import mtlooper_pkg::*;

  localparam int SEEK_CAP = (LOOP_DEPTH - 1 < 524287) ? LOOP_DEPTH - 1 : 524287;

  logic [CFG_W-1:0]  active_tracks;
  logic [4:0]        active_n;
  logic [MASK_W-1:0] track_en;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_tracks <= '0;
    end else if (cfg_valid) begin
      active_tracks <= cfg_data;
    end
  end

  // taking-part tracks: the first min(active_tracks, TRACKS)
  always_comb begin
    if (5'(active_tracks) > 5'(TRACKS)) begin
      active_n = 5'(TRACKS);
    end else begin
      active_n = 5'(active_tracks);
    end
    for (int t = 0; t < MASK_W; t++) begin
      track_en[t] = 5'(t) < active_n;
    end
  end

  always_comb begin
    push_data.action    = action_t'(action);
    push_data.sample    = sample_in;
    push_data.rec_mask  = record_mask & track_en;
    push_data.play_mask = play_mask & track_en;
    if (seek_position > SEEK_W'(SEEK_CAP)) begin
      push_data.seek = SEEK_W'(SEEK_CAP);
    end else begin
      push_data.seek = seek_position;
    end
  end

  assign push_valid = in_valid && !hold;
  assign in_ready   = push_ready && !hold;

endmodule

### design/mtlooper_queue.sv
// mtlooper_queue: two-entry command queue between front and back
// lets each side stall on its own; uses mtlooper_pkg
`timescale 1ns / 1ps

module mtlooper_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push_valid,
  output logic               push_ready,
  input  mtlooper_pkg::cmd_t push_data,
  output logic               pop_valid,
  input  logic               pop_ready,
  output mtlooper_pkg::cmd_t pop_data
);
  import mtlooper_pkg::*;

  cmd_t       entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign push_ready = count != 2'd2;
  assign pop_valid  = count != 2'd0;
  assign pop_data   = entry[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= push_data;
    end
  end

endmodule

### design/mtlooper_back.sv
// mtlooper_back: executes commands against the per-track loop rams,
// keeps positions and loop length, owns the output register
// uses mtlooper_pkg and mtlooper_ram
`timescale 1ns / 1ps

module mtlooper_back #(
  parameter int TRACKS     = 4,
  parameter int LOOP_DEPTH = 524288,
  parameter int WRITE_LAG  = 512
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    q_valid,
  output logic                                    q_ready,
  input  mtlooper_pkg::cmd_t                      q_data,
  output logic                                    init_busy,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [mtlooper_pkg::SAMPLE_W-1:0] sample_out,
  output logic                                    rollover
);
  import mtlooper_pkg::*;

  localparam int USED = (TRACKS < MASK_W) ? TRACKS : MASK_W;
  localparam int PW   = $clog2(LOOP_DEPTH);
  localparam int LW   = $clog2(LOOP_DEPTH + 1);
  localparam int AW   = (LW + 1 > 14) ? LW + 1 : 14;
  localparam logic [PW-1:0] CLR_LAST = PW'(LOOP_DEPTH - 1);

  bk_state_t state;
  bk_state_t state_next;

  cmd_t              cmd;
  logic [PW-1:0]     play_pos;
  logic [PW-1:0]     rec_pos;
  logic [LW-1:0]     loop_length;
  logic [PW-1:0]     clr_addr;
  logic              clr_result;
  logic [SAMPLE_W-1:0] res_sample;
  logic              res_roll;

  logic [PW-1:0]       rd_addr;
  logic [PW-1:0]       wr_addr;
  logic [SAMPLE_W-1:0] rdata [USED];
  logic [SAMPLE_W-1:0] wdata [USED];
  logic [USED-1:0]     we;

  logic [LW-1:0]       play_inc;
  logic [LW-1:0]       rec_inc;
  logic                play_wrap;
  logic                rec_wrap;
  logic [SAMPLE_W-1:0] acc;
  logic [AW-1:0]       seek_ext;
  logic [AW-1:0]       seek_sum;
  logic [PW-1:0]       seek_rec;

  // ---- loop rams, one per track that can take part
  for (genvar t = 0; t < USED; t++) begin : g_track
    mtlooper_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (LOOP_DEPTH)
    ) u_ram (
      .clk   (clk),
      .we    (we[t]),
      .waddr (wr_addr),
      .wdata (wdata[t]),
      .raddr (rd_addr),
      .rdata (rdata[t])
    );

    assign we[t]    = (state == S_CLEAR) || ((state == S_WREC) && cmd.rec_mask[t]);
    assign wdata[t] = (state == S_CLEAR) ? '0 : rdata[t] + $unsigned(cmd.sample);
  end

  assign rd_addr   = (state == S_RREC) ? rec_pos : play_pos;
  assign wr_addr   = (state == S_CLEAR) ? clr_addr : rec_pos;
  assign init_busy = (state == S_CLEAR) && !clr_result;

  // ---- position advance, wraps at loop length or end of store
  always_comb begin
    play_inc  = LW'(play_pos) + LW'(1);
    rec_inc   = LW'(rec_pos) + LW'(1);
    play_wrap = (play_inc >= loop_length) || (play_inc >= LW'(LOOP_DEPTH));
    rec_wrap  = (rec_inc >= loop_length) || (rec_inc >= LW'(LOOP_DEPTH));
  end

  // ---- mix of input and playing tracks
  always_comb begin
    acc = $unsigned(cmd.sample);
    for (int t = 0; t < USED; t++) begin
      if (cmd.play_mask[t]) begin
        acc = acc + rdata[t];
      end
    end
  end

  // ---- record position after a seek: lag behind, wrap once, else zero
  always_comb begin
    seek_ext = AW'(q_data.seek);
    seek_sum = seek_ext + AW'(loop_length);
    if (seek_ext >= AW'(WRITE_LAG)) begin
      seek_rec = PW'(seek_ext - AW'(WRITE_LAG));
    end else if (seek_sum >= AW'(WRITE_LAG)) begin
      seek_rec = PW'(seek_sum - AW'(WRITE_LAG));
    end else begin
      seek_rec = '0;
    end
  end

  // ---- sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_ready    = 1'b0;
    case (state)
      S_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          case (q_data.action)
            ACT_SAMPLE: state_next = S_RREC;
            ACT_CLEAR:  state_next = S_CLEAR;
            default:    state_next = S_OUT;
          endcase
        end
      end
      S_RREC:  state_next = S_WREC;
      S_WREC:  state_next = S_RPLAY;
      S_RPLAY: state_next = S_ACC;
      S_ACC:   state_next = S_OUT;
      S_OUT: begin
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end
      S_CLEAR: begin
        if (clr_addr == CLR_LAST) begin
          state_next = clr_result ? S_OUT : S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // ---- control and loop state
  always_ff @(posedge clk) begin
    if (rst) begin
      play_pos    <= '0;
      rec_pos     <= '0;
      loop_length <= LW'(LOOP_DEPTH);
      clr_addr    <= '0;
      clr_result  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (state == S_OUT && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            case (q_data.action)
              ACT_MARK: loop_length <= LW'(play_pos);
              ACT_SEEK: begin
                play_pos <= PW'(q_data.seek);
                rec_pos  <= seek_rec;
              end
              ACT_CLEAR: begin
                loop_length <= LW'(LOOP_DEPTH);
                clr_addr    <= '0;
                clr_result  <= 1'b1;
              end
              default: ;
            endcase
          end
        end
        S_ACC: begin
          play_pos <= play_wrap ? '0 : PW'(play_inc);
          rec_pos  <= rec_wrap ? '0 : PW'(rec_inc);
        end
        S_CLEAR: begin
          if (clr_addr == CLR_LAST) begin
            clr_addr   <= '0;
            clr_result <= 1'b0;
          end else begin
            clr_addr <= clr_addr + PW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // ---- payload
  always_ff @(posedge clk) begin
    if (state == S_IDLE && q_valid) begin
      cmd        <= q_data;
      res_sample <= '0;
      res_roll   <= 1'b0;
    end
    if (state == S_ACC) begin
      res_sample <= acc;
      res_roll   <= play_wrap;
    end
    if (state == S_OUT && (!out_valid || out_ready)) begin
      sample_out <= $signed(res_sample);
      rollover   <= res_roll;
    end
  end

`ifndef ASSERT_OFF
  a_pos_in_store: assert property (@(posedge clk) disable iff (rst)
    (play_pos <= CLR_LAST) && (rec_pos <= CLR_LAST))
    else $error("loop position beyond store");

  a_write_states: assert property (@(posedge clk) disable iff (rst)
    (|we) |-> (state == S_CLEAR || state == S_WREC))
    else $error("ram written outside clear or overdub");

  a_result_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_OUT))
    else $error("result loaded outside output state");

  a_clear_reports: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR && clr_addr == CLR_LAST && clr_result) |=> state == S_OUT)
    else $error("clear action finished without a result");

  a_pos_hold: assert property (@(posedge clk) disable iff (rst)
    (state != S_ACC && !(state == S_IDLE && q_valid)) |=> $stable(play_pos))
    else $error("play position moved outside sample or seek");
`endif

endmodule

### design/multitrack_overdub_looper_top.sv
// multitrack_overdub_looper_top: top level of the multitrack overdub looper
// front (classify) -> two-entry queue -> back (ram sequencer, output register)
// uses mtlooper_pkg, mtlooper_front, mtlooper_queue, mtlooper_back
`timescale 1ns / 1ps

//  channel  handshake              payload
//  -------  ---------------------  ------------------------------------------------
//  cfg      cfg_valid / cfg_ready  cfg_data (active_tracks)
//  in       in_valid / in_ready    action, sample_in, record_mask, play_mask,
//                                  seek_position
//  out      out_valid / out_ready  sample_out, rollover
//
//  a sample beat steps through the back end: one read of the record
//  slot, one overdub write, one read of the play slot, one mix, one load
//  of the output register, back to idle; mark and seek go from idle to
//  the output load, clear sweeps LOOP_DEPTH rows (one ram row, all tracks
//  at once, per cycle); reset starts a clearing pass over all rows;
//  in_ready stays low through it, config writes are taken at any time
//  the queue holds two beats, so the input side keeps taking beats while
//  the back end works or a result waits on out_ready, until the queue is full

module multitrack_overdub_looper_top #(
  parameter int TRACKS     = 4,
  parameter int LOOP_DEPTH = 524288,
  parameter int WRITE_LAG  = 512
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     cfg_valid,
  output logic                                     cfg_ready,
  input  logic [mtlooper_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic [mtlooper_pkg::ACTION_W-1:0]        action,
  input  logic signed [mtlooper_pkg::SAMPLE_W-1:0] sample_in,
  input  logic [mtlooper_pkg::MASK_W-1:0]          record_mask,
  input  logic [mtlooper_pkg::MASK_W-1:0]          play_mask,
  input  logic [mtlooper_pkg::SEEK_W-1:0]          seek_position,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic signed [mtlooper_pkg::SAMPLE_W-1:0] sample_out,
  output logic                                     rollover
);
  import mtlooper_pkg::*;

  // front to queue
  logic push_valid;
  logic push_ready;
  cmd_t push_data;

  // queue to back
  logic pop_valid;
  logic pop_ready;
  cmd_t pop_data;

  // high while the post-reset clearing pass runs
  logic init_busy;

  mtlooper_front #(
    .TRACKS     (TRACKS),
    .LOOP_DEPTH (LOOP_DEPTH)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .action        (action),
    .sample_in     (sample_in),
    .record_mask   (record_mask),
    .play_mask     (play_mask),
    .seek_position (seek_position),
    .hold          (init_busy),
    .push_valid    (push_valid),
    .push_ready    (push_ready),
    .push_data     (push_data)
  );

  // decouples classification from ram sequencing
  mtlooper_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // positions, loop length, per-track rams and the output register
  mtlooper_back #(
    .TRACKS     (TRACKS),
    .LOOP_DEPTH (LOOP_DEPTH),
    .WRITE_LAG  (WRITE_LAG)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (pop_valid),
    .q_ready    (pop_ready),
    .q_data     (pop_data),
    .init_busy  (init_busy),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sample_out (sample_out),
    .rollover   (rollover)
  );

endmodule

### tb/multitrack_overdub_looper_top_test.sv
// multitrack_overdub_looper_top_test: self-checking bench for the multitrack overdub looper
// drives action beats and track counts, predicts every mix and rollover, compares each output beat
// depends on mtlooper_pkg and multitrack_overdub_looper_top
`timescale 1ns / 1ps

module multitrack_overdub_looper_top_test;
  import mtlooper_pkg::*;

  // looper built at its full store depth; each clear sweeps the whole store
  localparam int TRACKS_N    = 4;
  localparam int LOOP_D      = 524288;
  localparam int LAG         = 512;
  localparam int CYCLE_LIMIT = 40_000_000;
  localparam int PHASE_BEATS = 250;

  typedef struct {
    action_t                    act;
    logic signed [SAMPLE_W-1:0] smp;
    logic        [MASK_W-1:0]   rec;
    logic        [MASK_W-1:0]   ply;
    logic        [SEEK_W-1:0]   seek;
  } beat_t;

  typedef struct {
    logic signed [SAMPLE_W-1:0] smp;
    logic                       roll;
  } mix_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CFG_W-1:0]           cfg_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [ACTION_W-1:0]        action = '0;
  logic signed [SAMPLE_W-1:0] sample_in = '0;
  logic [MASK_W-1:0]          record_mask = '0;
  logic [MASK_W-1:0]          play_mask = '0;
  logic [SEEK_W-1:0]          seek_position = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [SAMPLE_W-1:0] sample_out;
  logic                       rollover;

  // bench bookkeeping
  beat_t pending_beats[$];
  mix_t  mixes_due[$];
  int    fails = 0;
  int    cycle_count = 0;
  int    beats_sent = 0;   // beats handed to the driver
  int    beats_done = 0;   // output beats seen
  logic  steady = 1'b0;   // no idling on either side while set

  // predicted looper state
  logic [SAMPLE_W-1:0] track_mem [TRACKS_N][LOOP_D];
  logic [SEEK_W-1:0]   pos_play;
  logic [SEEK_W-1:0]   pos_rec;
  logic [SEEK_W:0]     len_loop;
  logic [CFG_W-1:0]    tracks_on;

  multitrack_overdub_looper_top #(
    .TRACKS     (TRACKS_N),
    .LOOP_DEPTH (LOOP_D),
    .WRITE_LAG  (LAG)
  ) u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .action        (action),
    .sample_in     (sample_in),
    .record_mask   (record_mask),
    .play_mask     (play_mask),
    .seek_position (seek_position),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .sample_out    (sample_out),
    .rollover      (rollover)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // position step: wraps at the loop length or at the end of the store
  function automatic logic [SEEK_W-1:0] next_pos(input logic [SEEK_W-1:0] p);
    logic [SEEK_W:0] q;
    q = p + 1'b1;
    if (q >= len_loop || q >= LOOP_D) return '0;
    return q[SEEK_W-1:0];
  endfunction

  // applies one accepted beat to the looper state and queues its output beat
  task automatic run_looper(input action_t act, input logic signed [SAMPLE_W-1:0] smp,
                            input logic [MASK_W-1:0] rec, input logic [MASK_W-1:0] ply,
                            input logic [SEEK_W-1:0] seek);
    mix_t                r;
    int                  n;
    int                  lagged;
    logic [SAMPLE_W-1:0] acc;
    logic [SEEK_W-1:0]   sk;
    r.smp  = '0;
    r.roll = 1'b0;
    case (act)
      ACT_SAMPLE: begin
        // track count saturates at the number of tracks and the mask width
        n = (tracks_on > TRACKS_N) ? TRACKS_N : int'(tracks_on);
        if (n > MASK_W) n = MASK_W;
        acc = smp;
        // overdub lands before the play read, so a shared slot plays the sum
        for (int t = 0; t < n; t++) begin
          if (rec[t]) track_mem[t][pos_rec] = track_mem[t][pos_rec] + smp;
          if (ply[t]) acc = acc + track_mem[t][pos_play];
        end
        pos_play = next_pos(pos_play);
        pos_rec  = next_pos(pos_rec);
        r.smp    = acc;
        r.roll   = (pos_play == '0);
      end
      ACT_MARK: begin
        len_loop = {1'b0, pos_play};
      end
      ACT_SEEK: begin
        // seek past the store clamps to its last slot
        sk = (seek >= LOOP_D) ? SEEK_W'(LOOP_D - 1) : seek;
        pos_play = sk;
        // record slot trails by the lag, wrapped once, else pinned at zero
        lagged = int'(sk) - LAG;
        if (lagged < 0) lagged += int'(len_loop);
        if (lagged < 0) lagged = 0;
        pos_rec = SEEK_W'(lagged);
      end
      ACT_CLEAR: begin
        foreach (track_mem[t, a]) track_mem[t][a] = '0;
        len_loop = (SEEK_W + 1)'(LOOP_D);
      end
    endcase
    mixes_due.push_back(r);
  endtask

  task automatic report_bad(input string what);
    fails++;
    if (fails <= 100) $display("%0t mismatch: %s", $realtime, what);
  endtask

  // ---------------------------------------------------------------------------
  // input side: presents queued beats, predicts each one as it is taken
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_in
    beat_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        run_looper(action_t'(action), sample_in, record_mask, play_mask, seek_position);
      end
      if (in_valid && !in_ready) begin
        // beat still waiting, hold everything
      end else if (pending_beats.size() != 0 && (steady || $urandom_range(99) >= 33)) begin
        nxt = pending_beats.pop_front();
        beats_sent++;
        in_valid      <= 1'b1;
        action        <= nxt.act;
        sample_in     <= nxt.smp;
        record_mask   <= nxt.rec;
        play_mask     <= nxt.ply;
        seek_position <= nxt.seek;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // output side: random backpressure, each output beat checked against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch_out
    mix_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        beats_done++;
        if (mixes_due.size() == 0) begin
          report_bad("output beat with no prediction pending");
        end else begin
          want = mixes_due.pop_front();
          if (sample_out !== want.smp)
            report_bad($sformatf("sample_out %h, predicted %h", sample_out, want.smp));
          if (rollover !== want.roll)
            report_bad($sformatf("rollover %b, predicted %b", rollover, want.roll));
        end
      end
      out_ready <= steady || ($urandom_range(99) >= 33);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("multitrack_overdub_looper_top_test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  task automatic add_beat(input action_t act, input logic signed [SAMPLE_W-1:0] smp,
                          input logic [MASK_W-1:0] rec, input logic [MASK_W-1:0] ply,
                          input logic [SEEK_W-1:0] seek);
    beat_t b;
    b.act  = act;
    b.smp  = smp;
    b.rec  = rec;
    b.ply  = ply;
    b.seek = seek;
    pending_beats.push_back(b);
  endtask

  // mostly sample beats with random content, a few marks and seeks,
  // clears rare since each one sweeps the whole store
  function automatic beat_t random_beat();
    beat_t b;
    int    pick;
    pick = $urandom_range(999);
    if (pick < 840)      b.act = ACT_SAMPLE;
    else if (pick < 890) b.act = ACT_MARK;
    else if (pick < 997) b.act = ACT_SEEK;
    else                 b.act = ACT_CLEAR;
    case ($urandom_range(9))
      0:       b.smp = 16'sh7fff;
      1:       b.smp = 16'sh8000;
      default: b.smp = SAMPLE_W'($urandom);
    endcase
    b.rec = MASK_W'($urandom_range(15));
    b.ply = MASK_W'($urandom_range(15));
    // seeks near zero exercise the lag wrap and the pin at zero
    case ($urandom_range(3))
      0:       b.seek = SEEK_W'($urandom);
      1:       b.seek = SEEK_W'($urandom_range(LAG));
      default: b.seek = SEEK_W'($urandom_range(LOOP_D - 1));
    endcase
    return b;
  endfunction

  // track count write, only while the looper is idle
  task automatic set_tracks(input logic [CFG_W-1:0] n);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= n;
    do @(posedge clk); while (!cfg_ready);
    tracks_on = n;
    cfg_valid <= 1'b0;
  endtask

  // every beat taken and every output beat seen
  task automatic wait_drained();
    while (pending_beats.size() != 0 || beats_done != beats_sent) @(posedge clk);
  endtask

  initial begin
    logic [CFG_W-1:0] phase_tracks [8];
    phase_tracks = '{3'd7, 3'd0, 3'd1, 3'd3, 3'd4, 3'd2, 3'd6, 3'd5};

    // predicted state after reset
    foreach (track_mem[t, a]) track_mem[t][a] = '0;
    pos_play  = '0;
    pos_rec   = '0;
    len_loop  = (SEEK_W + 1)'(LOOP_D);
    tracks_on = '0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // no tracks taking part yet: input goes straight through
    add_beat(ACT_SAMPLE, 16'sh1234, 4'hf, 4'hf, '0);
    wait_drained();

    set_tracks(3'd4);
    // both positions still equal: every track records then plays the same slot
    add_beat(ACT_SAMPLE, 16'sh7fff, 4'hf, 4'hf, '0);
    add_beat(ACT_SAMPLE, 16'sh8000, 4'hf, 4'h0, '0);
    // lag below zero wraps by the loop length
    add_beat(ACT_SEEK,   16'sh0000, 4'h0, 4'h0, 19'd1);
    add_beat(ACT_SAMPLE, 16'sh0001, 4'h0, 4'hf, '0);
    add_beat(ACT_SAMPLE, -16'sd1,   4'h5, 4'ha, '0);
    // short loop, then rollover on the next sample
    add_beat(ACT_MARK,   16'sh5555, 4'hf, 4'hf, 19'h7ffff);
    add_beat(ACT_SAMPLE, 16'sh0100, 4'hf, 4'hf, '0);
    add_beat(ACT_SAMPLE, 16'sh0200, 4'hf, 4'hf, '0);
    add_beat(ACT_SAMPLE, 16'sh0300, 4'hf, 4'hf, '0);
    // lag still negative after the wrap: record slot pinned at zero
    add_beat(ACT_SEEK,   16'sh0000, 4'h0, 4'h0, 19'd0);
    add_beat(ACT_SAMPLE, 16'sh4000, 4'hf, 4'hf, '0);
    // seek to the last slot of the store
    add_beat(ACT_SEEK,   16'shffff, 4'hf, 4'hf, 19'h7ffff);
    add_beat(ACT_SAMPLE, 16'sh0042, 4'h3, 4'hc, '0);
    // zero loop length: every advance wraps
    add_beat(ACT_MARK,   16'sh0000, 4'h0, 4'h0, '0);
    add_beat(ACT_SAMPLE, 16'sh7fff, 4'hf, 4'hf, '0);
    add_beat(ACT_SAMPLE, 16'sh8000, 4'hf, 4'hf, '0);
    add_beat(ACT_SEEK,   16'sh0000, 4'h0, 4'h0, 19'd100);
    // clear restores full length and empties the tracks
    add_beat(ACT_CLEAR,  16'sh7fff, 4'hf, 4'hf, 19'h7ffff);
    add_beat(ACT_SEEK,   16'sh0000, 4'h0, 4'h0, 19'd300);
    add_beat(ACT_SAMPLE, 16'sh1111, 4'h0, 4'hf, '0);
    add_beat(ACT_SAMPLE, 16'sh8000, 4'h0, 4'h0, 19'h40000);
    add_beat(ACT_MARK,   16'sh0000, 4'h0, 4'h0, '0);
    wait_drained();

    // random phases, each under its own track count; one phase runs with no idling
    for (int ph = 0; ph < 8; ph++) begin
      set_tracks(phase_tracks[ph]);
      steady = (ph == 4);
      for (int i = 0; i < PHASE_BEATS; i++) pending_beats.push_back(random_beat());
      wait_drained();
    end
    steady = 1'b0;

    // let any stray output beat show up before the verdict
    repeat (20) @(posedge clk);
    if (fails == 0 && mixes_due.size() == 0) begin
      $display("multitrack_overdub_looper_top_test passed");
    end else begin
      $display("multitrack_overdub_looper_top_test failed");
    end
    $finish;
  end

endmodule
